>>> hw/rtl/rgba_contrast_gamma_composite_unit_defines.svh
// Assertion macros shared by the checker of the compositing unit.
// No dependencies.
`ifndef RGBA_CONTRAST_GAMMA_COMPOSITE_UNIT_DEFINES_SVH
`define RGBA_CONTRAST_GAMMA_COMPOSITE_UNIT_DEFINES_SVH

// Same-cycle implication under an active-low reset.
`define RCG_ASSERT_NOW(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
	else $error("rcg check failed");

// Next-cycle implication under an active-low reset.
`define RCG_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
	else $error("rcg check failed");

`endif

>>> hw/rtl/rcg_pkg.sv
// Shared types, constants and elaboration-time functions of the compositing unit.
// No dependencies.
package rcg_pkg;

	localparam int unsigned CHANNEL_FRACTION_BITS = 16;
	localparam int unsigned LOG_BITS = 28;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned CFG_INDEX_W = 3;

	localparam logic [32:0] SRGB_KNEE = 33'd13446683;
	localparam logic [35:0] SRGB_SLOPE = 36'd55490977464;
	localparam logic [32:0] SRGB_SCALE = 33'd4531190497;
	localparam logic [33:0] SRGB_OFFSET = 34'd236223201;
	localparam logic [23:0] SRGB_EXPONENT = 24'd27307;
	localparam logic [23:0] EXPONENT_ONE = 24'd65536;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CONTRAST_EXPONENT = 3'd0,
		CFG_CONTRAST_FIXED    = 3'd1,
		CFG_INVERSE_GAMMA     = 3'd2,
		CFG_SRGB_MODE         = 3'd3,
		CFG_USE_BG_PIXEL      = 3'd4,
		CFG_BG_RED            = 3'd5,
		CFG_BG_GREEN          = 3'd6,
		CFG_BG_BLUE           = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [23:0] contrast_exponent;
		logic [15:0] contrast_fixed_level;
		logic [23:0] inverse_gamma;
		logic        srgb_mode;
		logic        use_background_pixel;
		logic [15:0] background_red;
		logic [15:0] background_green;
		logic [15:0] background_blue;
	} cfg_t;

	// Q0.16 to Q0.f, truncating.
	function automatic logic [31:0] to_level(input logic [15:0] q, input int unsigned f);
		return {q, 16'h0000} >> (32 - f);
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bit_v;
		logic [63:0] rem;
		rem = v;
		root = '0;
		bit_v = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (rem >= root + bit_v) begin
				rem = rem - (root + bit_v);
				root = (root >> 1) + bit_v;
			end else begin
				root = root >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return root;
	endfunction

	// 2^(-2^-idx) in Q0.32, by repeated square roots from one half.
	function automatic logic [31:0] exp_factor(input int unsigned idx);
		logic [63:0] c;
		c = 64'h8000_0000;
		for (int unsigned i = 1; i <= idx; i++) begin
			c = isqrt64(c << 32);
		end
		return c[31:0];
	endfunction

endpackage

>>> hw/rtl/rgba_contrast_gamma_composite_unit.sv
// Datapath: the divider (one stage per quotient bit) and two 60-stage power pipelines
// make up most of the pipeline from input transfer to result.
// Throughput: one pixel per clock; a skid register after the last stage takes one
// result while the output is stalled, and input stall is raised only while it is full.
// Reset: configuration registers return to their defaults and all valid bits clear.
// Depends on rcg_pkg and rcg_chan.
module rgba_contrast_gamma_composite_unit #(
	parameter int unsigned CHANNEL_FRACTION_BITS = rcg_pkg::CHANNEL_FRACTION_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [15:0]                     red_in,
	input  logic [15:0]                     green_in,
	input  logic [15:0]                     blue_in,
	input  logic [15:0]                     alpha_in,
	input  logic [7:0]                      bg_red_in,
	input  logic [7:0]                      bg_green_in,
	input  logic [7:0]                      bg_blue_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      red_out,
	output logic [7:0]                      green_out,
	output logic [7:0]                      blue_out,
	input  logic                            cfg_we,
	input  logic [rcg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rcg_pkg::CFG_DATA_W-1:0]  cfg_data
);
	localparam int unsigned F = CHANNEL_FRACTION_BITS;
	localparam int unsigned LW = F + 1;

	rcg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.contrast_exponent <= 24'd65536;
			cfg_q.contrast_fixed_level <= 16'd32768;
			cfg_q.inverse_gamma <= 24'd65536;
			cfg_q.srgb_mode <= 1'b0;
			cfg_q.use_background_pixel <= 1'b0;
			cfg_q.background_red <= '0;
			cfg_q.background_green <= '0;
			cfg_q.background_blue <= '0;
		end else if (cfg_we) begin
			unique case (rcg_pkg::cfg_idx_t'(cfg_index))
				rcg_pkg::CFG_CONTRAST_EXPONENT: cfg_q.contrast_exponent <= cfg_data;
				rcg_pkg::CFG_CONTRAST_FIXED: cfg_q.contrast_fixed_level <= cfg_data[15:0];
				rcg_pkg::CFG_INVERSE_GAMMA: cfg_q.inverse_gamma <= cfg_data;
				rcg_pkg::CFG_SRGB_MODE: cfg_q.srgb_mode <= cfg_data[0];
				rcg_pkg::CFG_USE_BG_PIXEL: cfg_q.use_background_pixel <= cfg_data[0];
				rcg_pkg::CFG_BG_RED: cfg_q.background_red <= cfg_data[15:0];
				rcg_pkg::CFG_BG_GREEN: cfg_q.background_green <= cfg_data[15:0];
				rcg_pkg::CFG_BG_BLUE: cfg_q.background_blue <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// byte / 255 in Q1.F, worked out at elaboration
	logic [LW-1:0] bg_lut [256];

	for (genvar g = 0; g < 256; g++) begin : g_bg_lut
		assign bg_lut[g] = LW'((64'(g) << F) / 64'd255);
	end

	logic en;
	logic skid_valid_q;

	assign en = !skid_valid_q;
	assign in_stall = skid_valid_q;

	// input stage: levels and background select
	logic          val_s1;
	logic [LW-1:0] lvl_s1   [3];
	logic [LW-1:0] bg_s1    [3];
	logic [LW-1:0] alpha_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
		end else if (en) begin
			val_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lvl_s1[0] <= LW'(rcg_pkg::to_level(red_in, F));
			lvl_s1[1] <= LW'(rcg_pkg::to_level(green_in, F));
			lvl_s1[2] <= LW'(rcg_pkg::to_level(blue_in, F));
			alpha_s1 <= LW'(rcg_pkg::to_level(alpha_in, F));
			if (cfg_q.use_background_pixel) begin
				bg_s1[0] <= bg_lut[bg_red_in];
				bg_s1[1] <= bg_lut[bg_green_in];
				bg_s1[2] <= bg_lut[bg_blue_in];
			end else begin
				bg_s1[0] <= LW'(rcg_pkg::to_level(cfg_q.background_red, F));
				bg_s1[1] <= LW'(rcg_pkg::to_level(cfg_q.background_green, F));
				bg_s1[2] <= LW'(rcg_pkg::to_level(cfg_q.background_blue, F));
			end
		end
	end

	logic [2:0] ch_valid;
	logic [7:0] ch_byte [3];

	for (genvar k = 0; k < 3; k++) begin : g_chan
		rcg_chan #(.F(F)) u_chan (
			.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q),
			.in_valid(val_s1), .level(lvl_s1[k]), .alpha(alpha_s1), .bg(bg_s1[k]),
			.out_valid(ch_valid[k]), .byte_out(ch_byte[k])
		);
	end

	logic last_valid;
	logic [7:0] skid_r_q, skid_g_q, skid_b_q;

	assign last_valid = &ch_valid;

	// hold a result that met a stall while the pipeline advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (!skid_valid_q) begin
			skid_valid_q <= last_valid && out_stall;
		end else if (!out_stall) begin
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q) begin
			skid_r_q <= ch_byte[0];
			skid_g_q <= ch_byte[1];
			skid_b_q <= ch_byte[2];
		end
	end

	assign out_valid = skid_valid_q || last_valid;
	assign red_out = skid_valid_q ? skid_r_q : ch_byte[0];
	assign green_out = skid_valid_q ? skid_g_q : ch_byte[1];
	assign blue_out = skid_valid_q ? skid_b_q : ch_byte[2];

endmodule

>>> hw/rtl/rcg_div.sv
// Pipelined restoring divider, one quotient bit per stage: quo = (num << F) / den, num <= den.
// Depends on rcg_pkg.
module rcg_div #(
	parameter int unsigned F = rcg_pkg::CHANNEL_FRACTION_BITS,
	parameter int unsigned SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [F:0]    num,
	input  logic [F:0]    den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [F:0]    quo,
	output logic [SW-1:0] side_out
);
	localparam int unsigned LW = F + 1;
	localparam int unsigned N = F + 1;

	logic          val_s  [1:N];
	logic [LW-1:0] rem_s  [1:N];
	logic [LW-1:0] den_s  [1:N];
	logic [LW-1:0] quo_s  [1:N];
	logic [SW-1:0] side_s [1:N];

	for (genvar k = 1; k <= N; k++) begin : g_stage
		logic          prev_val;
		logic [LW:0]   trial;
		logic [LW-1:0] prev_den;
		logic [LW-1:0] prev_quo;
		logic [SW-1:0] prev_side;
		logic          qbit;

		if (k == 1) begin : g_first
			assign prev_val = in_valid;
			assign trial = {1'b0, num};
			assign prev_den = den;
			assign prev_quo = '0;
			assign prev_side = side_in;
		end else begin : g_next
			assign prev_val = val_s[k-1];
			assign trial = {rem_s[k-1], 1'b0};
			assign prev_den = den_s[k-1];
			assign prev_quo = quo_s[k-1];
			assign prev_side = side_s[k-1];
		end

		assign qbit = trial >= {1'b0, prev_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[k] <= 1'b0;
			end else if (en) begin
				val_s[k] <= prev_val;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= qbit ? LW'(trial - {1'b0, prev_den}) : LW'(trial);
				den_s[k] <= prev_den;
				quo_s[k] <= {prev_quo[LW-2:0], qbit};
				side_s[k] <= prev_side;
			end
		end
	end

	assign out_valid = val_s[N];
	assign quo = quo_s[N];
	assign side_out = side_s[N];

endmodule

>>> hw/rtl/rcg_pow.sv
// Pipelined fixed-point power x^e: log2 by squaring stages, one multiply, 2^-t by factor stages.
// Depends on rcg_pkg.
module rcg_pow #(
	parameter int unsigned F = rcg_pkg::CHANNEL_FRACTION_BITS,
	parameter int unsigned SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [F:0]    x,
	input  logic [23:0]   e,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [F:0]    y,
	output logic [SW-1:0] side_out
);
	localparam int unsigned LW = F + 1;
	localparam int unsigned LB = rcg_pkg::LOG_BITS;
	localparam int unsigned PW = $clog2(F + 1);
	localparam int unsigned NLW = PW + LB;
	localparam int unsigned MW = NLW + 24;
	localparam int unsigned TW = NLW + 8;
	localparam int unsigned NW = TW - LB;
	localparam logic [LW-1:0] ONE = {1'b1, {F{1'b0}}};

	typedef struct packed {
		logic force_one;
		logic force_zero;
	} pflag_t;

	// normalize
	logic [PW-1:0] p_in;
	logic [30:0]   m_in;
	pflag_t        flag_in;

	always_comb begin
		p_in = '0;
		for (int j = 0; j < F; j++) begin
			if (x[j]) begin
				p_in = PW'(j);
			end
		end
	end

	assign m_in = 31'(x) << (6'd30 - 6'(p_in));
	assign flag_in.force_one = (e == '0) || (x >= ONE);
	assign flag_in.force_zero = (x == '0);

	// log section: stage 0 is the normalize register
	logic          lval_s  [0:LB];
	logic [30:0]   lm_s    [0:LB];
	logic [LB-1:0] lfrac_s [0:LB];
	logic [PW-1:0] lp_s    [0:LB];
	pflag_t        lflag_s [0:LB];
	logic [SW-1:0] lside_s [0:LB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lval_s[0] <= 1'b0;
		end else if (en) begin
			lval_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lm_s[0] <= m_in;
			lfrac_s[0] <= '0;
			lp_s[0] <= p_in;
			lflag_s[0] <= flag_in;
			lside_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= LB; k++) begin : g_log
		logic [61:0] sq;
		logic [31:0] m2;

		assign sq = 62'(lm_s[k-1]) * 62'(lm_s[k-1]);
		assign m2 = sq[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lval_s[k] <= 1'b0;
			end else if (en) begin
				lval_s[k] <= lval_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lm_s[k] <= m2[31] ? m2[31:1] : m2[30:0];
				lfrac_s[k] <= {lfrac_s[k-1][LB-2:0], m2[31]};
				lp_s[k] <= lp_s[k-1];
				lflag_s[k] <= lflag_s[k-1];
				lside_s[k] <= lside_s[k-1];
			end
		end
	end

	// -log2(x) in Q.28
	logic           val_s1;
	logic [NLW-1:0] nl_s1;
	pflag_t         flag_s1;
	logic [SW-1:0]  side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
		end else if (en) begin
			val_s1 <= lval_s[LB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nl_s1 <= {PW'(F) - lp_s[LB], {LB{1'b0}}} - NLW'(lfrac_s[LB]);
			flag_s1 <= lflag_s[LB];
			side_s1 <= lside_s[LB];
		end
	end

	// t = L*e, split into shift count and fraction
	logic [MW-1:0] t_full;
	logic [TW-1:0] t_val;
	logic [NW-1:0] t_int;
	pflag_t        flag_t;

	assign t_full = MW'(nl_s1) * MW'(e);
	assign t_val = t_full[MW-1:16];
	assign t_int = t_val[TW-1:LB];
	assign flag_t.force_one = flag_s1.force_one;
	assign flag_t.force_zero = flag_s1.force_zero || (t_int > NW'(32));

	// exp section: stage 0 holds t
	logic          xval_s  [0:LB];
	logic [32:0]   xr_s    [0:LB];
	logic [LB-1:0] xf_s    [0:LB];
	logic [5:0]    xn_s    [0:LB];
	pflag_t        xflag_s [0:LB];
	logic [SW-1:0] xside_s [0:LB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xval_s[0] <= 1'b0;
		end else if (en) begin
			xval_s[0] <= val_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xr_s[0] <= {1'b1, 32'h0};
			xf_s[0] <= t_val[LB-1:0];
			xn_s[0] <= t_int[5:0];
			xflag_s[0] <= flag_t;
			xside_s[0] <= side_s1;
		end
	end

	for (genvar k = 1; k <= LB; k++) begin : g_exp
		localparam logic [31:0] FAC = rcg_pkg::exp_factor(k);
		logic [64:0] prod;

		assign prod = 65'(xr_s[k-1]) * 65'(FAC);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				xval_s[k] <= 1'b0;
			end else if (en) begin
				xval_s[k] <= xval_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				xr_s[k] <= xf_s[k-1][LB-k] ? prod[64:32] : xr_s[k-1];
				xf_s[k] <= xf_s[k-1];
				xn_s[k] <= xn_s[k-1];
				xflag_s[k] <= xflag_s[k-1];
				xside_s[k] <= xside_s[k-1];
			end
		end
	end

	// integer shift and cut to Q1.F
	logic [32:0]   r_sh;
	logic [32:0]   r_cut;
	logic          val_s2;
	logic [LW-1:0] y_s2;
	logic [SW-1:0] side_s2;

	assign r_sh = xr_s[LB] >> xn_s[LB];
	assign r_cut = r_sh >> (32 - F);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s2 <= 1'b0;
		end else if (en) begin
			val_s2 <= xval_s[LB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (xflag_s[LB].force_one) begin
				y_s2 <= ONE;
			end else if (xflag_s[LB].force_zero) begin
				y_s2 <= '0;
			end else begin
				y_s2 <= LW'(r_cut);
			end
			side_s2 <= xside_s[LB];
		end
	end

	assign out_valid = val_s2;
	assign y = y_s2;
	assign side_out = side_s2;

endmodule

>>> hw/rtl/rcg_chan.sv
// One color channel: contrast curve, transfer curve, blend over background, byte quantize.
// Depends on rcg_pkg, rcg_div, rcg_pow.
module rcg_chan #(
	parameter int unsigned F = rcg_pkg::CHANNEL_FRACTION_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  rcg_pkg::cfg_t cfg,
	input  logic          in_valid,
	input  logic [F:0]    level,
	input  logic [F:0]    alpha,
	input  logic [F:0]    bg,
	output logic          out_valid,
	output logic [7:0]    byte_out
);
	localparam int unsigned LW = F + 1;
	localparam int unsigned SW1 = 3 * LW + 1;
	localparam int unsigned SW2 = 3 * LW;
	localparam int unsigned CPW = 2 * LW;
	localparam int unsigned SCW = LW + 33;
	localparam int unsigned LNW = LW + 36;
	localparam int unsigned BSW = 2 * LW + 1;
	localparam logic [LW-1:0] ONE = {1'b1, {F{1'b0}}};

	logic [LW-1:0] c_lvl;
	logic          skip;

	assign c_lvl = LW'(rcg_pkg::to_level(cfg.contrast_fixed_level, F));
	assign skip = cfg.contrast_exponent == rcg_pkg::EXPONENT_ONE;

	// branch select and division operands
	logic          val_s1;
	logic [LW-1:0] num_s1, den_s1, v_s1, alpha_s1, bg_s1;
	logic          lower_s1;
	logic          lower_in;

	assign lower_in = level < c_lvl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
		end else if (en) begin
			val_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= lower_in ? level : ONE - level;
			den_s1 <= lower_in ? c_lvl : ONE - c_lvl;
			v_s1 <= level;
			alpha_s1 <= alpha;
			bg_s1 <= bg;
			lower_s1 <= lower_in;
		end
	end

	logic           dv_valid;
	logic [LW-1:0]  dv_quo;
	logic [SW1-1:0] dv_side;

	rcg_div #(.F(F), .SW(SW1)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(val_s1), .num(num_s1), .den(den_s1),
		.side_in({v_s1, alpha_s1, bg_s1, lower_s1}),
		.out_valid(dv_valid), .quo(dv_quo), .side_out(dv_side)
	);

	logic           pc_valid;
	logic [LW-1:0]  pc_y;
	logic [SW1-1:0] pc_side;

	rcg_pow #(.F(F), .SW(SW1)) u_pow_contrast (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(dv_valid), .x(dv_quo), .e(cfg.contrast_exponent),
		.side_in(dv_side),
		.out_valid(pc_valid), .y(pc_y), .side_out(pc_side)
	);

	// map the curve back around the fixed level
	logic [LW-1:0]  pc_v, pc_alpha, pc_bg;
	logic           pc_lower;
	logic [LW-1:0]  mul_a, mul_b;
	logic [CPW-1:0] mul_p;
	logic [LW-1:0]  mul_cut;
	logic [LW-1:0]  curve;

	assign {pc_v, pc_alpha, pc_bg, pc_lower} = pc_side;
	assign mul_a = pc_lower ? pc_y : ONE - pc_y;
	assign mul_b = pc_lower ? c_lvl : ONE - c_lvl;
	assign mul_p = CPW'(mul_a) * CPW'(mul_b);
	assign mul_cut = LW'(mul_p >> F);
	assign curve = pc_lower ? mul_cut : c_lvl + mul_cut;

	logic          val_s2;
	logic [LW-1:0] vc_s2, alpha_s2, bg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s2 <= 1'b0;
		end else if (en) begin
			val_s2 <= pc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vc_s2 <= skip ? pc_v : curve;
			alpha_s2 <= pc_alpha;
			bg_s2 <= pc_bg;
		end
	end

	logic           pt_valid;
	logic [LW-1:0]  pt_y;
	logic [SW2-1:0] pt_side;

	rcg_pow #(.F(F), .SW(SW2)) u_pow_transfer (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(val_s2), .x(vc_s2),
		.e(cfg.srgb_mode ? rcg_pkg::SRGB_EXPONENT : cfg.inverse_gamma),
		.side_in({vc_s2, alpha_s2, bg_s2}),
		.out_valid(pt_valid), .y(pt_y), .side_out(pt_side)
	);

	// sRGB products: linear segment and scaled power
	logic [LW-1:0]  pt_v, pt_alpha, pt_bg;
	logic [LNW-1:0] lin_p;

	assign {pt_v, pt_alpha, pt_bg} = pt_side;
	assign lin_p = LNW'(pt_v) * LNW'(rcg_pkg::SRGB_SLOPE);

	logic           val_s3;
	logic [LW-1:0]  gam_s3, lin_s3, alpha_s3, bg_s3;
	logic [SCW-1:0] scl_s3;
	logic           knee_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s3 <= 1'b0;
		end else if (en) begin
			val_s3 <= pt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gam_s3 <= pt_y;
			scl_s3 <= SCW'(pt_y) * SCW'(rcg_pkg::SRGB_SCALE);
			lin_s3 <= LW'(lin_p >> 32);
			knee_s3 <= (64'(pt_v) << (32 - F)) <= 64'(rcg_pkg::SRGB_KNEE);
			alpha_s3 <= pt_alpha;
			bg_s3 <= pt_bg;
		end
	end

	// offset, cut and clamp
	logic [33:0]   s_scl, s_off, s_cut;
	logic [LW-1:0] s_clamp;
	logic [LW-1:0] v_xfer;

	assign s_scl = 34'(scl_s3 >> F);
	assign s_off = (s_scl > rcg_pkg::SRGB_OFFSET) ? s_scl - rcg_pkg::SRGB_OFFSET : '0;
	assign s_cut = s_off >> (32 - F);
	assign s_clamp = (s_cut > 34'(ONE)) ? ONE : LW'(s_cut);
	assign v_xfer = !cfg.srgb_mode ? gam_s3 : (knee_s3 ? lin_s3 : s_clamp);

	logic          val_s4;
	logic [LW-1:0] vt_s4, alpha_s4, bg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s4 <= 1'b0;
		end else if (en) begin
			val_s4 <= val_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vt_s4 <= v_xfer;
			alpha_s4 <= alpha_s3;
			bg_s4 <= bg_s3;
		end
	end

	// blend products
	logic           val_s5;
	logic [CPW-1:0] pa_s5, pb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s5 <= 1'b0;
		end else if (en) begin
			val_s5 <= val_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s5 <= CPW'(alpha_s4) * CPW'(vt_s4);
			pb_s5 <= CPW'(ONE - alpha_s4) * CPW'(bg_s4);
		end
	end

	// sum, quantize, saturate
	logic [BSW-1:0] sum;
	logic [BSW-1:0] q;
	logic           val_s6;
	logic [7:0]     byte_s6;

	assign sum = BSW'(pa_s5) + BSW'(pb_s5);
	assign q = sum >> (2 * F - 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s6 <= 1'b0;
		end else if (en) begin
			val_s6 <= val_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byte_s6 <= (q > BSW'(255)) ? 8'd255 : q[7:0];
		end
	end

	assign out_valid = val_s6;
	assign byte_out = byte_s6;

endmodule

>>> hw/rtl/rcg_checker.sv
// Port-level checks of the compositing unit, bound to the top level.
// Depends on rgba_contrast_gamma_composite_unit_defines.svh.
`include "rgba_contrast_gamma_composite_unit_defines.svh"

module rcg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out
);

	`RCG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out))

	`RCG_ASSERT_NOW(a_stall_has_result, clk, arst_n, in_stall, out_valid)

	`RCG_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, $past(out_valid && out_stall))

	`RCG_ASSERT_NEXT(a_stall_drains, clk, arst_n, in_stall && !out_stall, !in_stall)

	// input side sees stall only while a result waits; a valid input is never held without one
	`RCG_ASSERT_NOW(a_idle_no_stall, clk, arst_n, !out_valid, !in_stall || !in_valid)

endmodule

bind rgba_contrast_gamma_composite_unit rcg_checker u_rcg_checker (.*);

>>> tb/sv/rgba_contrast_gamma_composite_unit_test.sv
// Self-checking testbench for rgba_contrast_gamma_composite_unit: pixel driver, result
// monitor and a bit-exact fixed-point predictor of contrast, transfer curve and blend.
// Depends on rcg_pkg and the unit RTL.
`timescale 1ns / 1ps

module rgba_contrast_gamma_composite_unit_test;

	typedef logic [63:0] u64_t;
	localparam int FB = 16;
	localparam int LB = rcg_pkg::LOG_BITS;
	localparam u64_t ONE = u64_t'(1) << FB;
	localparam int SETTLE_CYCLES = 200;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [15:0] red, green, blue, alpha;
		logic [7:0]  bg_red, bg_green, bg_blue;
	} pixel_t;

	typedef struct {
		logic [7:0] red, green, blue;
	} rgb8_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [15:0] red_in = 0, green_in = 0, blue_in = 0, alpha_in = 0;
	logic [7:0] bg_red_in = 0, bg_green_in = 0, bg_blue_in = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [7:0] red_out, green_out, blue_out;
	logic cfg_we = 0;
	logic [rcg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [rcg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	rgba_contrast_gamma_composite_unit dut (.*);

	pixel_t pending_pixels[$];
	rgb8_t expected_rgb[$];
	rcg_pkg::cfg_t regs;
	u64_t root_factor[1:LB];
	int errors = 0;
	int pixels_sent = 0;
	int pixels_checked = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit calm = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic u64_t int_sqrt(input u64_t v);
		logic [127:0] root;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			if (((root | (128'd1 << b)) * (root | (128'd1 << b))) <= v)
				root = root | (128'd1 << b);
		end
		return root[63:0];
	endfunction

	function automatic u64_t q16_to_level(input logic [15:0] q);
		return u64_t'(q);
	endfunction

	// x in Q0.16, e in Q8.16
	function automatic u64_t power_q(input u64_t x, input u64_t e);
		u64_t m, frac, nl, t, f, r, n;
		int msb;
		if (e == 0 || x >= ONE) return ONE;
		if (x == 0) return 0;
		msb = 0;
		while ((x >> (msb + 1)) != 0) msb++;
		m = x << (30 - msb);
		frac = 0;
		for (int i = 0; i < LB; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (u64_t'(2) << 30)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		nl = (u64_t'(FB - msb) << LB) - frac;
		t = (nl * e) >> 16;
		n = t >> LB;
		f = t & ((u64_t'(1) << LB) - 1);
		if (n > 32) return 0;
		r = u64_t'(1) << 32;
		for (int i = 1; i <= LB; i++)
			if (f[LB - i]) r = (r * root_factor[i]) >> 32;
		r = r >> n;
		return r >> (32 - FB);
	endfunction

	function automatic u64_t contrast_curve(input u64_t v);
		u64_t c, e, p;
		c = q16_to_level(regs.contrast_fixed_level);
		e = u64_t'(regs.contrast_exponent);
		if (v < c) begin
			p = power_q((v << FB) / c, e);
			return (p * c) >> FB;
		end
		p = power_q(((ONE - v) << FB) / (ONE - c), e);
		return c + (((ONE - p) * (ONE - c)) >> FB);
	endfunction

	function automatic u64_t transfer_curve(input u64_t v);
		u64_t s;
		if (!regs.srgb_mode) return power_q(v, u64_t'(regs.inverse_gamma));
		if ((v << (32 - FB)) <= u64_t'(rcg_pkg::SRGB_KNEE))
			return (v * u64_t'(rcg_pkg::SRGB_SLOPE)) >> 32;
		s = (power_q(v, u64_t'(rcg_pkg::SRGB_EXPONENT)) * u64_t'(rcg_pkg::SRGB_SCALE)) >> FB;
		s = (s > u64_t'(rcg_pkg::SRGB_OFFSET)) ? s - u64_t'(rcg_pkg::SRGB_OFFSET) : 0;
		s = s >> (32 - FB);
		return (s > ONE) ? ONE : s;
	endfunction

	function automatic logic [7:0] composite_channel(input logic [15:0] lvl, input u64_t alpha,
			input u64_t bg);
		u64_t v, q;
		v = q16_to_level(lvl);
		if (regs.contrast_exponent != rcg_pkg::EXPONENT_ONE) v = contrast_curve(v);
		v = transfer_curve(v);
		q = (alpha * v + (ONE - alpha) * bg) >> (2 * FB - 8);
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	function automatic rgb8_t composite_pixel(input pixel_t px);
		rgb8_t o;
		u64_t a, br, bgn, bb;
		a = q16_to_level(px.alpha);
		if (regs.use_background_pixel) begin
			br = (u64_t'(px.bg_red) << FB) / 255;
			bgn = (u64_t'(px.bg_green) << FB) / 255;
			bb = (u64_t'(px.bg_blue) << FB) / 255;
		end else begin
			br = q16_to_level(regs.background_red);
			bgn = q16_to_level(regs.background_green);
			bb = q16_to_level(regs.background_blue);
		end
		o.red = composite_channel(px.red, a, br);
		o.green = composite_channel(px.green, a, bgn);
		o.blue = composite_channel(px.blue, a, bb);
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH result %0d %s", pixels_checked, msg);
		errors++;
	endtask

	// Driver: advance to the next pixel after each transfer, hold while stalled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_rgb.push_back(composite_pixel(pending_pixels.pop_front()));
				pixels_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 0;
				end else if (pending_pixels.size() > 0) begin
					in_valid <= 1;
					red_in <= pending_pixels[0].red;
					green_in <= pending_pixels[0].green;
					blue_in <= pending_pixels[0].blue;
					alpha_in <= pending_pixels[0].alpha;
					bg_red_in <= pending_pixels[0].bg_red;
					bg_green_in <= pending_pixels[0].bg_green;
					bg_blue_in <= pending_pixels[0].bg_blue;
					if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// Monitor: compare each result transfer with the oldest prediction.
	always @(posedge clk) begin
		rgb8_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_rgb.size() == 0) begin
					report_mismatch($sformatf("unexpected: %0d %0d %0d",
						red_out, green_out, blue_out));
				end else begin
					want = expected_rgb.pop_front();
					if (red_out !== want.red)
						report_mismatch($sformatf("red: got %0d expected %0d",
							red_out, want.red));
					if (green_out !== want.green)
						report_mismatch($sformatf("green: got %0d expected %0d",
							green_out, want.green));
					if (blue_out !== want.blue)
						report_mismatch($sformatf("blue: got %0d expected %0d",
							blue_out, want.blue));
				end
				pixels_checked++;
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				recv_gap = $urandom_range(0, 15);
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(input rcg_pkg::cfg_idx_t idx, input logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			rcg_pkg::CFG_CONTRAST_EXPONENT: regs.contrast_exponent = val;
			rcg_pkg::CFG_CONTRAST_FIXED:    regs.contrast_fixed_level = val[15:0];
			rcg_pkg::CFG_INVERSE_GAMMA:     regs.inverse_gamma = val;
			rcg_pkg::CFG_SRGB_MODE:         regs.srgb_mode = val[0];
			rcg_pkg::CFG_USE_BG_PIXEL:      regs.use_background_pixel = val[0];
			rcg_pkg::CFG_BG_RED:            regs.background_red = val[15:0];
			rcg_pkg::CFG_BG_GREEN:          regs.background_green = val[15:0];
			rcg_pkg::CFG_BG_BLUE:           regs.background_blue = val[15:0];
			default: ;
		endcase
	endtask

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		px.red = pick16();
		px.green = pick16();
		px.blue = pick16();
		px.alpha = pick16();
		px.bg_red = 8'($urandom_range(0, 255));
		px.bg_green = 8'($urandom_range(0, 255));
		px.bg_blue = 8'($urandom_range(0, 255));
		return px;
	endfunction

	task automatic drain();
		wait (pending_pixels.size() == 0 && !in_valid && expected_rgb.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		pixel_t px;
		logic [23:0] ex, gm;
		logic [15:0] fx;
		u64_t c;
		c = u64_t'(1) << 31;
		for (int i = 1; i <= LB; i++) begin
			c = int_sqrt(c << 32);
			root_factor[i] = c;
		end
		regs.contrast_exponent = 24'd65536;
		regs.contrast_fixed_level = 16'd32768;
		regs.inverse_gamma = 24'd65536;
		regs.srgb_mode = 0;
		regs.use_background_pixel = 0;
		regs.background_red = 0;
		regs.background_green = 0;
		regs.background_blue = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// Directed corners under reset defaults: extreme, near-extreme and mid-scale field values and alpha end points.
		for (int i = 0; i < 16; i++) begin
			px.red = i[0] ? 16'hFFFF : 16'h0000;
			px.green = i[1] ? 16'hFFFF : 16'h0001;
			px.blue = i[2] ? 16'h8000 : 16'h7FFF;
			px.alpha = i[3] ? 16'hFFFF : 16'h0000;
			px.bg_red = i[0] ? 8'hFF : 8'h00;
			px.bg_green = i[1] ? 8'hAA : 8'h55;
			px.bg_blue = i[2] ? 8'h00 : 8'hFF;
			pending_pixels.push_back(px);
		end
		drain();

		for (int p = 1; p <= 10; p++) begin
			case (p % 5)
				0: ex = 24'd65536;
				1: ex = 24'd0;
				2: ex = 24'hFFFFFF;
				3: ex = 24'($urandom_range(16384, 262144));
				default: ex = 24'($urandom_range(0, 24'hFFFFFF));
			endcase
			case (p % 4)
				0: fx = 16'h0000;
				1: fx = 16'hFFFF;
				2: fx = 16'h8000;
				default: fx = 16'($urandom_range(1, 65534));
			endcase
			case (p % 6)
				0: gm = 24'd0;
				1: gm = 24'd1;
				2: gm = 24'hFFFFFF;
				3: gm = 24'd27307;
				default: gm = 24'($urandom_range(20000, 200000));
			endcase
			write_reg(rcg_pkg::CFG_CONTRAST_EXPONENT, ex);
			write_reg(rcg_pkg::CFG_CONTRAST_FIXED, {8'h00, fx});
			write_reg(rcg_pkg::CFG_INVERSE_GAMMA, gm);
			write_reg(rcg_pkg::CFG_SRGB_MODE, {23'd0, p[0]});
			write_reg(rcg_pkg::CFG_USE_BG_PIXEL, {23'd0, p[1]});
			write_reg(rcg_pkg::CFG_BG_RED, {8'h00, pick16()});
			write_reg(rcg_pkg::CFG_BG_GREEN, {8'h00, pick16()});
			write_reg(rcg_pkg::CFG_BG_BLUE, {8'h00, pick16()});
			calm = (p == 10);
			for (int i = 0; i < 75; i++) pending_pixels.push_back(random_pixel());
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d pixels over 11 register settings, checked %0d results.",
			pixels_sent, pixels_checked);
		if (errors == 0 && expected_rgb.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_rgb.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/rcg_pkg.sv
hw/rtl/rcg_div.sv
hw/rtl/rcg_pow.sv
hw/rtl/rcg_chan.sv
hw/rtl/rgba_contrast_gamma_composite_unit.sv
hw/rtl/rcg_checker.sv
tb/sv/rgba_contrast_gamma_composite_unit_test.sv
